FILE: src/gn1d_pkg.sv
// ----------------------------------------------------------------------------
// gn1d_pkg
// Shared types and constants of the 1D gradient noise pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gn1d_pkg;

	// defaults of the top level parameters
	localparam int NUM_POINTS_DEF     = 4096;
	localparam int GRADIENT_COUNT_DEF = 64;

	// field widths
	localparam int IDX_W    = 12;
	localparam int STEP_W   = 22;
	localparam int SIGNS_W  = 64;
	localparam int AMP_W    = 10;
	localparam int OUT_W    = 27;
	localparam int POS_W    = IDX_W + STEP_W;
	localparam int LAT_W    = POS_W - 16;
	localparam int FRAC_W   = 16;
	localparam int CFG_IDX_W = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_SIGNS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE      = 2'd2;

	// register reset values
	localparam logic [STEP_W-1:0]  STEP_RST  = 22'd4096;
	localparam logic [SIGNS_W-1:0] SIGNS_RST = 64'd0;
	localparam logic [AMP_W-1:0]   AMP_RST   = 10'd16;

	// fixed point constants
	localparam logic [16:0] FRAC_ONE   = 17'd65536;
	localparam int          HALF_LSB   = 32768;
	localparam int          FADE_C6    = 6;
	localparam int          FADE_C15   = 15;
	localparam int          FADE_C10   = 10;
	localparam logic [OUT_W-1:0] OUT_POS_LIM = 27'd33554431;
	localparam logic [OUT_W-1:0] OUT_NEG_LIM = 27'd33554432;

	// cycles from accepted item to result strobe
	localparam int LATENCY = 7;

	// configuration register set
	typedef struct packed {
		logic [STEP_W-1:0]  sample_step;
		logic [SIGNS_W-1:0] gradient_signs;
		logic [AMP_W-1:0]   amplitude;
	} gn1d_cfg_t;

	// per item side information carried along the pipeline
	typedef struct packed {
		logic              oor;
		logic              gl;
		logic              gr;
		logic [FRAC_W-1:0] d;
	} gn1d_side_t;

endpackage

`default_nettype wire

FILE: src/gn1d_cfg_regs.sv
// ----------------------------------------------------------------------------
// gn1d_cfg_regs
// Configuration register file: step, gradient sign mask and amplitude.
// ----------------------------------------------------------------------------
`default_nettype none

module gn1d_cfg_regs
	import gn1d_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data,
	output gn1d_cfg_t                 cfg
);

	logic [STEP_W-1:0]  sample_step_q;
	logic [SIGNS_W-1:0] gradient_signs_q;
	logic [AMP_W-1:0]   amplitude_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_step_q    <= STEP_RST;
			gradient_signs_q <= SIGNS_RST;
			amplitude_q      <= AMP_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SAMPLE_STEP:    sample_step_q    <= cfg_data[STEP_W-1:0];
				REG_GRADIENT_SIGNS: gradient_signs_q <= cfg_data[SIGNS_W-1:0];
				REG_AMPLITUDE:      amplitude_q      <= cfg_data[AMP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.sample_step    = sample_step_q;
	assign cfg.gradient_signs = gradient_signs_q;
	assign cfg.amplitude      = amplitude_q;

endmodule

`default_nettype wire

FILE: src/gn1d_fade.sv
// ----------------------------------------------------------------------------
// gn1d_fade
// Quintic fade t = 6d^5 - 15d^4 + 10d^3 in three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module gn1d_fade
	import gn1d_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire gn1d_side_t in_side,
	output logic            out_valid,
	output gn1d_side_t      out_side,
	output logic [16:0]     out_t
);

	logic        valid_s2, valid_s3, valid_s4;
	gn1d_side_t  side_s2, side_s3, side_s4;
	logic [16:0] d2_s2;
	logic [16:0] d3_s3;
	logic [20:0] p_s3;
	logic [16:0] t_s4;

	logic [32:0] sq_rnd;
	logic [33:0] cube_rnd;
	logic [21:0] p_sum, p_sub;
	logic [38:0] t_rnd;
	logic [22:0] t_raw;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage 2: d2 = round(d*d)
	assign sq_rnd = 33'(32'(in_side.d) * 32'(in_side.d)) + 33'(HALF_LSB);

	always_ff @(posedge clk) begin
		side_s2 <= in_side;
		d2_s2   <= 17'(sq_rnd >> 16);
	end

	// stage 3: d3 = round(d2*d), polynomial p = 6*d2 - 15*d + 10
	assign cube_rnd = 34'(33'(d2_s2) * 33'(side_s2.d)) + 34'(HALF_LSB);
	assign p_sum    = 22'(d2_s2) * 22'(FADE_C6) + 22'(FADE_C10) * 22'(FRAC_ONE);
	assign p_sub    = 22'(side_s2.d) * 22'(FADE_C15);

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		d3_s3   <= 17'(cube_rnd >> 16);
		p_s3    <= (p_sum < p_sub) ? 21'd0 : 21'(p_sum - p_sub);
	end

	// stage 4: t = round(d3*p), clamped to one
	assign t_rnd = 39'(d3_s3) * 39'(p_s3) + 39'(HALF_LSB);
	assign t_raw = 23'(t_rnd >> 16);

	always_ff @(posedge clk) begin
		side_s4 <= side_s3;
		t_s4    <= (t_raw > 23'(FRAC_ONE)) ? FRAC_ONE : t_raw[16:0];
	end

	assign out_valid = valid_s4;
	assign out_side  = side_s4;
	assign out_t     = t_s4;

endmodule

`default_nettype wire

FILE: src/gn1d_blend.sv
// ----------------------------------------------------------------------------
// gn1d_blend
// Gradient blend, amplitude scale, rounding and saturation of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module gn1d_blend
	import gn1d_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire gn1d_side_t       in_side,
	input  wire logic [16:0]      in_t,
	input  wire logic [AMP_W-1:0] amplitude,
	output logic                  out_valid,
	output logic [OUT_W-1:0]      out_height,
	output logic                  out_oor
);

	logic        valid_s5, valid_s6, valid_s7;
	logic        oor_s5, gl_s5, gr_s5, oor_s6, oor_s7;
	logic [32:0] a_s5;
	logic [33:0] b_s5;
	logic signed [45:0] vm_s6;
	logic [OUT_W-1:0]   height_s7;

	logic [16:0]        one_m_t, one_m_d;
	logic signed [35:0] a_sg, b_sg, v;
	logic signed [45:0] amp_sg;
	logic               neg;
	logic [45:0]        mag;
	logic [29:0]        rnd;
	logic [OUT_W-1:0]   lim, mag_sat, res;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s5 <= in_valid;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// stage 5: a = d*(1-t), b = (1-d)*t
	assign one_m_t = FRAC_ONE - in_t;
	assign one_m_d = FRAC_ONE - 17'(in_side.d);

	always_ff @(posedge clk) begin
		oor_s5 <= in_side.oor;
		gl_s5  <= in_side.gl;
		gr_s5  <= in_side.gr;
		a_s5   <= 33'(in_side.d) * 33'(one_m_t);
		b_s5   <= 34'(one_m_d) * 34'(in_t);
	end

	// stage 6: v = gL*a - gR*b, times amplitude
	assign a_sg   = $signed({3'b000, a_s5});
	assign b_sg   = $signed({2'b00, b_s5});
	assign v      = (gl_s5 ? a_sg : -a_sg) + (gr_s5 ? -b_sg : b_sg);
	assign amp_sg = $signed({36'd0, amplitude});

	always_ff @(posedge clk) begin
		oor_s6 <= oor_s5;
		vm_s6  <= 46'(v) * amp_sg;
	end

	// stage 7: round half away from zero, saturate, zero when out of range
	assign neg     = vm_s6[45];
	assign mag     = neg ? 46'(-vm_s6) : 46'(vm_s6);
	assign rnd     = 30'((mag + 46'(HALF_LSB)) >> 16);
	assign lim     = neg ? OUT_NEG_LIM : OUT_POS_LIM;
	assign mag_sat = (rnd > 30'(lim)) ? lim : rnd[OUT_W-1:0];
	assign res     = neg ? (~mag_sat + 27'd1) : mag_sat;

	always_ff @(posedge clk) begin
		oor_s7    <= oor_s6;
		height_s7 <= oor_s6 ? '0 : res;
	end

	assign out_valid  = valid_s7;
	assign out_height = height_s7;
	assign out_oor    = oor_s7;

endmodule

`default_nettype wire

FILE: src/gradient_noise_1d.sv
// ----------------------------------------------------------------------------
// gradient_noise_1d
// One sample of 1D gradient noise with quintic fade per point index.
// ----------------------------------------------------------------------------
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  input     | start, busy            | point_index
//  result    | done (one cycle)       | height_offset, out_of_range
//  config    | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
//  Seven register stages: position multiply, fade square, fade cube and
//  polynomial, fade product, blend products, amplitude multiply, round/clamp.
//  One item per cycle; each result strobes done as it leaves the round/clamp stage.
//  busy and cfg_ready stay constant; nothing in the pipe ever waits.
//  Reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module gradient_noise_1d
	import gn1d_pkg::*;
#(
	parameter int NUM_POINTS     = NUM_POINTS_DEF,
	parameter int GRADIENT_COUNT = GRADIENT_COUNT_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [IDX_W-1:0]     point_index,
	output logic                      done,
	output logic signed [OUT_W-1:0]   height_offset,
	output logic                      out_of_range,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data
);

	gn1d_cfg_t   cfg;
	logic        valid_s1;
	logic [POS_W-1:0] pos_s1;
	logic        idx_oor_s1;
	logic [LAT_W-1:0] lat;
	logic [5:0]  lat_lo;
	logic        lat_oor;
	gn1d_side_t  side_s1;
	logic        fade_valid;
	gn1d_side_t  fade_side;
	logic [16:0] fade_t;
	logic [OUT_W-1:0] height;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	gn1d_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1: position = index * step, index range check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1     <= POS_W'(point_index) * POS_W'(cfg.sample_step);
		idx_oor_s1 <= 17'(point_index) >= 17'(NUM_POINTS);
	end

	// lattice decode and gradient lookup
	assign lat     = pos_s1[POS_W-1:FRAC_W];
	assign lat_lo  = lat[5:0];
	assign lat_oor = (19'(lat) + 19'd1) >= 19'(GRADIENT_COUNT);

	assign side_s1.oor = idx_oor_s1 || lat_oor;
	assign side_s1.gl  = cfg.gradient_signs[lat_lo];
	assign side_s1.gr  = cfg.gradient_signs[lat_lo + 6'd1];
	assign side_s1.d   = pos_s1[FRAC_W-1:0];

	gn1d_fade u_fade (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_side   (side_s1),
		.out_valid (fade_valid),
		.out_side  (fade_side),
		.out_t     (fade_t)
	);

	gn1d_blend u_blend (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (fade_valid),
		.in_side    (fade_side),
		.in_t       (fade_t),
		.amplitude  (cfg.amplitude),
		.out_valid  (done),
		.out_height (height),
		.out_oor    (out_of_range)
	);

	assign height_offset = $signed(height);

endmodule

`default_nettype wire

FILE: src/gn1d_checker.sv
// ----------------------------------------------------------------------------
// gn1d_checker
// Port level checks of the noise pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gn1d_checker
	import gn1d_pkg::*;
#(
	parameter int NUM_POINTS = NUM_POINTS_DEF
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 start,
	input wire logic                 busy,
	input wire logic [IDX_W-1:0]     point_index,
	input wire logic                 done,
	input wire logic [OUT_W-1:0]     height_offset,
	input wire logic                 out_of_range,
	input wire logic                 cfg_valid,
	input wire logic                 cfg_ready
);

	// every accepted item gives its result strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result strobe missing after accepted item");

	// an index at or beyond the point count comes back flagged
	a_idx_oor: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (17'(point_index) >= 17'(NUM_POINTS)))
		|-> ##LATENCY (done && out_of_range))
		else $error("out of range index not flagged");

	// flagged results carry zero
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_range) |-> (height_offset == '0))
		else $error("flagged result is not zero");

	// no result without an item in flight
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##LATENCY !done)
		else $error("result strobe without item");

	// register writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write held off");

endmodule

bind gradient_noise_1d gn1d_checker #(.NUM_POINTS(NUM_POINTS)) u_gn1d_checker (.*);

`default_nettype wire
